// File: src/lavm_pkg.sv
// look-at view matrix: shared widths, types, codes and command/status structs
// used by the normalize unit, the datapath, the controller and the top level
`default_nettype none

package lavm_pkg;

	// fixed-point formats
	localparam int COORD_FRAC_BITS = 16;
	localparam int UNIT_FRAC_BITS  = 14;
	localparam int COORD_W         = 32;
	localparam int UNIT_W          = 16;
	localparam int DIFF_W          = COORD_W + 1;
	localparam int UPROD_W         = 2 * UNIT_W + 1;
	localparam int ACC_W           = COORD_W + UNIT_W + 2;

	// normalize unit sizing: the largest magnitude is scaled into [2^(NORM_HI-1), 2^NORM_HI)
	localparam int MAG_W    = DIFF_W;
	localparam int NORM_HI  = 30;
	localparam int SUMSQ_W  = 2 * NORM_HI + 2;
	localparam int ROOT_W   = SUMSQ_W / 2;
	localparam int REM_W    = ROOT_W + 3;
	localparam int DREM_W   = ROOT_W + 1;
	localparam int QUO_W    = UNIT_FRAC_BITS + 2;
	localparam int NUM_W    = NORM_HI + UNIT_FRAC_BITS + 1;
	localparam int CNT_W    = $clog2(ROOT_W + 1);

	// constants
	localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
	localparam int ROUND_HALF     = 1 << (UNIT_FRAC_BITS - 1);
	localparam int STEP_TWENTIETH = ((1 << COORD_FRAC_BITS) + 10) / 20;
	localparam int EYE_Z_RESET    = 5 << COORD_FRAC_BITS;

	// command kinds
	localparam logic [1:0] KIND_LOOK = 2'd0;
	localparam logic [1:0] KIND_AIM  = 2'd1;
	localparam logic [1:0] KIND_MOVE = 2'd2;

	// last axis / component index
	localparam logic [1:0] LAST_AXIS = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       norm_start;
		logic       norm_sel;
		logic       keep_b;
		logic       up_en;
		logic       commit;
		logic       orbit_step;
		logic       tr_mac;
		logic       tr_fin;
		logic       emit;
		logic [1:0] idx;
		logic [1:0] col;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       norm_done;
		logic       norm_ok;
		logic [1:0] kind;
		logic       orbit;
	} stat_t;

endpackage

`default_nettype wire

// File: src/lavm_norm.sv
// look-at view matrix: iterative vector normalize unit
// power-of-two scaling, sum of squares, bit-serial square root and division; uses lavm_pkg
`default_nettype none

module lavm_norm import lavm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire diff_t vec [3],
	output logic       done,
	output logic       ok,
	output unit_t      unit_vec [3]
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SCALE = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_ROOT  = 3'd3;
	localparam logic [2:0] N_DINIT = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	logic [2:0]         st_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         idx_q;
	logic               done_q;
	logic               ok_q;

	logic [MAG_W-1:0]   mag_q [3];
	logic [2:0]         neg_q;
	logic [SUMSQ_W-1:0] sum_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [DREM_W-1:0]  drem_q;
	logic [QUO_W-1:0]   nlo_q;
	logic [QUO_W-1:0]   quo_q;

	logic [MAG_W-1:0]   mag_in [3];
	logic               all_zero;
	logic               big;
	logic               low;
	logic [NORM_HI-1:0] mag_sel;
	logic [SUMSQ_W-1:0] sq;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic               root_ge;
	logic [NUM_W-1:0]   num;
	logic [DREM_W-1:0]  dtry;
	logic               div_ge;
	logic [QUO_W-1:0]   quo_d;
	logic [QUO_W-1:0]   quo_cap;

	// magnitudes of the incoming vector
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec[i][DIFF_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
		end
		all_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
	end

	// scaling decision
	always_comb begin
		big = (|mag_q[0][MAG_W-1:NORM_HI]) | (|mag_q[1][MAG_W-1:NORM_HI]) |
			(|mag_q[2][MAG_W-1:NORM_HI]);
		low = ~(mag_q[0][NORM_HI-1] | mag_q[1][NORM_HI-1] | mag_q[2][NORM_HI-1]);
	end

	// square of the selected component
	assign mag_sel = mag_q[idx_q][NORM_HI-1:0];
	assign sq      = SUMSQ_W'(mag_sel) * SUMSQ_W'(mag_sel);

	// one square root digit
	always_comb begin
		rem_sh  = {rem_q[REM_W-3:0], sum_q[SUMSQ_W-1 -: 2]};
		trial   = REM_W'({root_q, 2'b01});
		root_ge = rem_sh >= trial;
	end

	// one quotient bit, rounded numerator
	always_comb begin
		num     = NUM_W'({mag_sel, UNIT_FRAC_BITS'(0)}) + NUM_W'(root_q >> 1);
		dtry    = {drem_q[ROOT_W-1:0], nlo_q[QUO_W-1]};
		div_ge  = dtry >= DREM_W'(root_q);
		quo_d   = {quo_q[QUO_W-2:0], div_ge};
		quo_cap = (quo_d > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : quo_d;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= N_IDLE;
			cnt_q  <= '0;
			idx_q  <= '0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						if (all_zero) begin
							done_q <= 1'b1;
							ok_q   <= 1'b0;
						end else begin
							st_q <= N_SCALE;
						end
					end
				end
				N_SCALE: begin
					if (!big && !low) begin
						st_q  <= N_SQ;
						idx_q <= '0;
					end
				end
				N_SQ: begin
					if (idx_q == LAST_AXIS) begin
						st_q  <= N_ROOT;
						cnt_q <= CNT_W'(ROOT_W);
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				N_ROOT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						st_q  <= N_DINIT;
						idx_q <= '0;
					end
				end
				N_DINIT: begin
					st_q  <= N_DIV;
					cnt_q <= CNT_W'(QUO_W);
				end
				N_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						if (idx_q == LAST_AXIS) begin
							st_q   <= N_IDLE;
							done_q <= 1'b1;
							ok_q   <= 1'b1;
						end else begin
							st_q  <= N_DINIT;
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_in[i];
						neg_q[i] <= vec[i][DIFF_W-1];
					end
				end
			end
			N_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					if (big) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (low) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
				sum_q <= '0;
			end
			N_SQ: begin
				sum_q  <= sum_q + sq;
				rem_q  <= '0;
				root_q <= '0;
			end
			N_ROOT: begin
				sum_q <= sum_q << 2;
				if (root_ge) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			N_DINIT: begin
				drem_q <= DREM_W'(num[NUM_W-1:QUO_W]);
				nlo_q  <= num[QUO_W-1:0];
				quo_q  <= '0;
			end
			N_DIV: begin
				drem_q <= div_ge ? (dtry - DREM_W'(root_q)) : dtry;
				nlo_q  <= nlo_q << 1;
				quo_q  <= quo_d;
				if (cnt_q == CNT_W'(1)) begin
					unit_vec[idx_q] <= neg_q[idx_q] ? -UNIT_W'(quo_cap) : UNIT_W'(quo_cap);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign ok   = ok_q;

endmodule

`default_nettype wire

// File: src/lavm_dp.sv
// look-at view matrix: datapath with camera points, basis, cross products and translation
// driven by cmd_t from lavm_ctrl; instantiates lavm_norm; uses lavm_pkg
`default_nettype none

module lavm_dp import lavm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output stat_t           stat,
	input  wire logic [1:0] kind,
	input  wire coord_t     first_x,
	input  wire coord_t     first_y,
	input  wire coord_t     first_z,
	input  wire coord_t     target_x,
	input  wire coord_t     target_y,
	input  wire coord_t     target_z,
	input  wire logic       orbit,
	output unit_t           right_x,
	output unit_t           right_y,
	output unit_t           right_z,
	output unit_t           upward_x,
	output unit_t           upward_y,
	output unit_t           upward_z,
	output unit_t           back_x,
	output unit_t           back_y,
	output unit_t           back_z,
	output coord_t          shift_x,
	output coord_t          shift_y,
	output coord_t          shift_z
);

	// saturate a widened coordinate back to its own width
	function automatic coord_t sat_coord(input diff_t v);
		if (v[DIFF_W-1] != v[COORD_W-1]) begin
			return {v[DIFF_W-1], {(COORD_W-1){~v[DIFF_W-1]}}};
		end
		return v[COORD_W-1:0];
	endfunction

	// shift right by the unit fraction, half away from zero
	function automatic logic signed [UPROD_W-1:0] rshift_round(
		input logic signed [UPROD_W-1:0] v);
		logic [UPROD_W-1:0] m;
		m = v[UPROD_W-1] ? UPROD_W'(-v) : UPROD_W'(v);
		m = (m + UPROD_W'(ROUND_HALF)) >> UNIT_FRAC_BITS;
		return v[UPROD_W-1] ? -$signed(m) : $signed(m);
	endfunction

	logic [1:0]          kind_q;
	logic                orbit_q;
	coord_t              eye_q [3];
	coord_t              aim_q [3];
	unit_t               basis_q [9];
	unit_t               b_q [3];
	unit_t               up_q [3];
	logic signed [ACC_W-1:0] acc_q;
	coord_t              tshift_q [3];
	unit_t               obasis_q [9];
	coord_t              oshift_q [3];

	coord_t              first_v [3];
	coord_t              target_v [3];
	diff_t               norm_vec [3];
	logic                norm_done;
	logic                norm_ok;
	unit_t               nvec [3];
	logic signed [2*UNIT_W-1:0] pa;
	logic signed [2*UNIT_W-1:0] pb;
	logic signed [UPROD_W-1:0]  up_rs;
	unit_t               up_val;
	logic signed [UPROD_W-1:0]  off [3];
	logic [3:0]          bidx;
	logic signed [COORD_W+UNIT_W-1:0] prod;
	logic                tneg;
	logic [ACC_W-1:0]    amag;
	logic [ACC_W-1:0]    rmag;
	logic [ACC_W-1:0]    lim;
	coord_t              tval;

	assign first_v  = '{first_x, first_y, first_z};
	assign target_v = '{target_x, target_y, target_z};

	// normalize operand: eye minus aim, or world up cross back
	always_comb begin
		if (cmd.norm_sel) begin
			norm_vec[0] = DIFF_W'(b_q[2]);
			norm_vec[1] = '0;
			norm_vec[2] = -DIFF_W'(b_q[0]);
		end else begin
			for (int i = 0; i < 3; i++) begin
				norm_vec[i] = DIFF_W'(eye_q[i]) - DIFF_W'(aim_q[i]);
			end
		end
	end

	lavm_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.norm_start),
		.vec      (norm_vec),
		.done     (norm_done),
		.ok       (norm_ok),
		.unit_vec (nvec)
	);

	// one up component: back cross right
	always_comb begin
		unique case (cmd.idx)
			2'd0: begin
				pa = b_q[1] * nvec[2];
				pb = b_q[2] * nvec[1];
			end
			2'd1: begin
				pa = b_q[2] * nvec[0];
				pb = b_q[0] * nvec[2];
			end
			2'd2: begin
				pa = b_q[0] * nvec[1];
				pb = b_q[1] * nvec[0];
			end
			default: begin
				pa = '0;
				pb = '0;
			end
		endcase
		up_rs = rshift_round(UPROD_W'(pa) - UPROD_W'(pb));
		if (up_rs > UPROD_W'(UNIT_ONE)) begin
			up_val = UNIT_W'(UNIT_ONE);
		end else if (up_rs < -UPROD_W'(UNIT_ONE)) begin
			up_val = -UNIT_W'(UNIT_ONE);
		end else begin
			up_val = up_rs[UNIT_W-1:0];
		end
	end

	// step along the back axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = rshift_round(UPROD_W'(basis_q[6+i]) * UPROD_W'(STEP_TWENTIETH));
		end
	end

	// translation product and row finish
	always_comb begin
		bidx = {1'b0, cmd.idx, 1'b0} + {2'b00, cmd.idx} + {2'b00, cmd.col};
		prod = basis_q[bidx] * eye_q[cmd.col];
		tneg = acc_q[ACC_W-1];
		amag = tneg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		rmag = (amag + ACC_W'(ROUND_HALF)) >> UNIT_FRAC_BITS;
		lim  = ACC_W'(1) << (COORD_W - 1);
		if (tneg) begin
			tval = (rmag >= lim) ? {1'b0, {(COORD_W-1){1'b1}}} : rmag[COORD_W-1:0];
		end else begin
			tval = (rmag > lim) ? {1'b1, {(COORD_W-1){1'b0}}} : -rmag[COORD_W-1:0];
		end
	end

	// command latch and camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_LOOK;
			orbit_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				eye_q[i] <= (i == 2) ? COORD_W'(EYE_Z_RESET) : COORD_W'(0);
				aim_q[i] <= '0;
			end
			for (int i = 0; i < 9; i++) begin
				basis_q[i] <= (i == 0 || i == 4 || i == 8) ? UNIT_W'(UNIT_ONE) : UNIT_W'(0);
			end
		end else begin
			if (cmd.load) begin
				kind_q  <= kind;
				orbit_q <= orbit;
				unique case (kind)
					KIND_LOOK: begin
						eye_q <= first_v;
						aim_q <= target_v;
					end
					KIND_AIM: aim_q <= first_v;
					KIND_MOVE: begin
						for (int i = 0; i < 3; i++) begin
							eye_q[i] <= sat_coord(DIFF_W'(eye_q[i]) + DIFF_W'(first_v[i]));
							aim_q[i] <= sat_coord(DIFF_W'(aim_q[i]) + DIFF_W'(first_v[i]));
						end
					end
					default: ;
				endcase
			end else if (cmd.orbit_step) begin
				for (int i = 0; i < 3; i++) begin
					aim_q[i] <= eye_q[i];
					eye_q[i] <= sat_coord(DIFF_W'(eye_q[i]) + DIFF_W'(off[i]));
				end
			end
			if (cmd.commit) begin
				for (int i = 0; i < 3; i++) begin
					basis_q[i]   <= nvec[i];
					basis_q[3+i] <= up_q[i];
					basis_q[6+i] <= b_q[i];
				end
			end
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		if (cmd.keep_b) begin
			b_q <= nvec;
		end
		if (cmd.up_en) begin
			up_q[cmd.idx] <= up_val;
		end
		if (cmd.load || cmd.tr_fin) begin
			acc_q <= '0;
		end else if (cmd.tr_mac) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (cmd.tr_fin) begin
			tshift_q[cmd.idx] <= tval;
		end
		if (cmd.emit) begin
			obasis_q <= basis_q;
			oshift_q <= tshift_q;
		end
	end

	assign stat = '{norm_done: norm_done, norm_ok: norm_ok, kind: kind_q, orbit: orbit_q};

	assign right_x  = obasis_q[0];
	assign right_y  = obasis_q[1];
	assign right_z  = obasis_q[2];
	assign upward_x = obasis_q[3];
	assign upward_y = obasis_q[4];
	assign upward_z = obasis_q[5];
	assign back_x   = obasis_q[6];
	assign back_y   = obasis_q[7];
	assign back_z   = obasis_q[8];
	assign shift_x  = oshift_q[0];
	assign shift_y  = oshift_q[1];
	assign shift_z  = oshift_q[2];

endmodule

`default_nettype wire

// File: src/lavm_ctrl.sv
// look-at view matrix: controller state machine and handshakes
// issues cmd_t to lavm_dp and reads stat_t back; uses lavm_pkg
`default_nettype none

module lavm_ctrl import lavm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [3:0] C_IDLE   = 4'd0;
	localparam logic [3:0] C_DISP   = 4'd1;
	localparam logic [3:0] C_NB_W   = 4'd2;
	localparam logic [3:0] C_NR     = 4'd3;
	localparam logic [3:0] C_NR_W   = 4'd4;
	localparam logic [3:0] C_UP     = 4'd5;
	localparam logic [3:0] C_COMMIT = 4'd6;
	localparam logic [3:0] C_ORB    = 4'd7;
	localparam logic [3:0] C_TR     = 4'd8;
	localparam logic [3:0] C_FIN    = 4'd9;
	localparam logic [3:0] C_EMIT   = 4'd10;

	logic [3:0] st_q, st_d;
	logic [1:0] row_q, row_d;
	logic [1:0] col_q, col_d;
	logic       ovalid_q;

	// next state and commands
	always_comb begin
		cmd   = '0;
		st_d  = st_q;
		row_d = row_q;
		col_d = col_q;
		cmd.idx = row_q;
		cmd.col = col_q;
		unique case (st_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = C_DISP;
				end
			end
			C_DISP: begin
				if (stat.kind == KIND_LOOK || stat.kind == KIND_AIM) begin
					cmd.norm_start = 1'b1;
					st_d           = C_NB_W;
				end else begin
					st_d = C_ORB;
				end
			end
			C_NB_W: begin
				if (stat.norm_done) begin
					if (stat.norm_ok) begin
						cmd.keep_b = 1'b1;
						st_d       = C_NR;
					end else begin
						st_d = C_ORB;
					end
				end
			end
			C_NR: begin
				cmd.norm_start = 1'b1;
				cmd.norm_sel   = 1'b1;
				st_d           = C_NR_W;
			end
			C_NR_W: begin
				if (stat.norm_done) begin
					row_d = '0;
					st_d  = stat.norm_ok ? C_UP : C_ORB;
				end
			end
			C_UP: begin
				cmd.up_en = 1'b1;
				if (row_q == LAST_AXIS) begin
					st_d = C_COMMIT;
				end else begin
					row_d = row_q + 2'd1;
				end
			end
			C_COMMIT: begin
				cmd.commit = 1'b1;
				st_d       = C_ORB;
			end
			C_ORB: begin
				cmd.orbit_step = (stat.kind == KIND_LOOK) && !stat.orbit;
				row_d = '0;
				col_d = '0;
				st_d  = C_TR;
			end
			C_TR: begin
				cmd.tr_mac = 1'b1;
				if (col_q == LAST_AXIS) begin
					st_d = C_FIN;
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			C_FIN: begin
				cmd.tr_fin = 1'b1;
				col_d      = '0;
				if (row_q == LAST_AXIS) begin
					st_d = C_EMIT;
				end else begin
					row_d = row_q + 2'd1;
					st_d  = C_TR;
				end
			end
			C_EMIT: begin
				if (!ovalid_q || out_ready) begin
					cmd.emit = 1'b1;
					st_d     = C_IDLE;
				end
			end
			default: st_d = C_IDLE;
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= C_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			row_q <= row_d;
			col_q <= col_d;
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (st_q == C_IDLE);
	assign out_valid = ovalid_q;

endmodule

`default_nettype wire

// File: src/look_at_view_matrix.sv
// look-at view matrix: top level joining the controller and the datapath
// depends on lavm_pkg, lavm_ctrl, lavm_dp (with lavm_norm)
//
// Takes one camera command per input transaction (look from a point to a target,
// look at a target, or move) and returns one transaction with the three basis axes
// in signed Q1.14 and the saturated Q15.16 translation. Look and look-at make two
// passes through the shared normalize unit, each starting with power-of-two scaling
// steps; a zero-length back axis skips the second pass. Each pass runs the square
// root (two radicand bits per cycle) and, per component, the divider (one quotient
// bit per cycle). The result is held in an output register, so the next input
// transaction is taken while the last result waits.
`default_nettype none

module look_at_view_matrix import lavm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] kind,
	input  wire coord_t     first_x,
	input  wire coord_t     first_y,
	input  wire coord_t     first_z,
	input  wire coord_t     target_x,
	input  wire coord_t     target_y,
	input  wire coord_t     target_z,
	input  wire logic       orbit,
	output logic            out_valid,
	input  wire logic       out_ready,
	output unit_t           right_x,
	output unit_t           right_y,
	output unit_t           right_z,
	output unit_t           upward_x,
	output unit_t           upward_y,
	output unit_t           upward_z,
	output unit_t           back_x,
	output unit_t           back_y,
	output unit_t           back_z,
	output coord_t          shift_x,
	output coord_t          shift_y,
	output coord_t          shift_z
);

	cmd_t  cmd;
	stat_t stat;

	lavm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lavm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.kind     (kind),
		.first_x  (first_x),
		.first_y  (first_y),
		.first_z  (first_z),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.orbit    (orbit),
		.right_x  (right_x),
		.right_y  (right_y),
		.right_z  (right_z),
		.upward_x (upward_x),
		.upward_y (upward_y),
		.upward_z (upward_z),
		.back_x   (back_x),
		.back_y   (back_y),
		.back_z   (back_z),
		.shift_x  (shift_x),
		.shift_y  (shift_y),
		.shift_z  (shift_z)
	);

endmodule

`default_nettype wire

// File: test/tb_look_at_view_matrix.sv
// testbench for look_at_view_matrix: directed and random camera commands,
// checked against an in-bench predictor; depends on lavm_pkg and the rtl
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
	import lavm_pkg::*;

	localparam int TIMEOUT_CYCLES = 2000000;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic signed [15:0] ax[9];
		logic signed [31:0] sh[3];
	} view_t;

	// camera predictor and queue of expected views
	class view_board;
		longint eye[3];
		longint aim[3];
		longint bas[9];
		view_t pending[$];
		int errors;

		function new();
			eye = '{0, 0, EYE_Z_RESET};
			aim = '{0, 0, 0};
			bas = '{UNIT_ONE, 0, 0, 0, UNIT_ONE, 0, 0, 0, UNIT_ONE};
			errors = 0;
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint rnd_shift(longint v);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (64'sd1 << (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
			return (v < 0) ? -m : m;
		endfunction

		function longint clamp_unit(longint v);
			if (v > UNIT_ONE) return UNIT_ONE;
			if (v < -UNIT_ONE) return -UNIT_ONE;
			return v;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// unit vector, returns 0 for a zero-length input
		function bit unit(input longint d[3], output longint u[3]);
			longint unsigned m[3], top, len, q;
			top = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = (d[i] < 0) ? -d[i] : d[i];
				if (m[i] > top) top = m[i];
			end
			if (top == 0) return 0;
			while (top >= (64'd1 << 30)) begin
				top >>= 1;
				for (int i = 0; i < 3; i++) m[i] >>= 1;
			end
			while (top < (64'd1 << 29)) begin
				top <<= 1;
				for (int i = 0; i < 3; i++) m[i] <<= 1;
			end
			len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << UNIT_FRAC_BITS) + (len >> 1)) / len;
				if (q > UNIT_ONE) q = UNIT_ONE;
				u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		function void rebuild();
			longint d[3], c[3], b[3], r[3];
			for (int i = 0; i < 3; i++) d[i] = eye[i] - aim[i];
			if (!unit(d, b)) return;
			c = '{b[2], 0, -b[0]};
			if (!unit(c, r)) return;
			for (int i = 0; i < 3; i++) begin
				bas[i] = r[i];
				bas[6 + i] = b[i];
			end
			bas[3] = clamp_unit(rnd_shift(b[1] * r[2] - b[2] * r[1]));
			bas[4] = clamp_unit(rnd_shift(b[2] * r[0] - b[0] * r[2]));
			bas[5] = clamp_unit(rnd_shift(b[0] * r[1] - b[1] * r[0]));
		endfunction

		// note an accepted command and queue the view it produces
		function void note_command(logic [1:0] k, coord_t f[3], coord_t t[3], logic orb);
			view_t v;
			longint s;
			if (k == KIND_LOOK) begin
				for (int i = 0; i < 3; i++) begin
					eye[i] = f[i];
					aim[i] = t[i];
				end
				rebuild();
				if (!orb)
					for (int i = 0; i < 3; i++) begin
						aim[i] = eye[i];
						eye[i] = sat(eye[i] + rnd_shift(bas[6 + i] * STEP_TWENTIETH));
					end
			end else if (k == KIND_AIM) begin
				for (int i = 0; i < 3; i++) aim[i] = f[i];
				rebuild();
			end else if (k == KIND_MOVE) begin
				for (int i = 0; i < 3; i++) begin
					eye[i] = sat(eye[i] + f[i]);
					aim[i] = sat(aim[i] + f[i]);
				end
			end
			for (int i = 0; i < 9; i++) v.ax[i] = 16'(bas[i]);
			for (int a = 0; a < 3; a++) begin
				s = 0;
				for (int i = 0; i < 3; i++) s += bas[3 * a + i] * eye[i];
				v.sh[a] = 32'(sat(-rnd_shift(s)));
			end
			pending.push_back(v);
		endfunction

		function void check_view(view_t got);
			view_t w;
			string names[12];
			names = '{"right_x", "right_y", "right_z", "upward_x", "upward_y", "upward_z",
				"back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			w = pending.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.ax[i] !== w.ax[i]) begin
					$error("%s expected %0d got %0d", names[i], w.ax[i], got.ax[i]);
					errors++;
				end
			for (int i = 0; i < 3; i++)
				if (got.sh[i] !== w.sh[i]) begin
					$error("%s expected %0d got %0d", names[9 + i], w.sh[i], got.sh[i]);
					errors++;
				end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready, orbit;
	logic [1:0] kind;
	coord_t first_x, first_y, first_z, target_x, target_y, target_z;
	unit_t right_x, right_y, right_z, upward_x, upward_y, upward_z, back_x, back_y, back_z;
	coord_t shift_x, shift_y, shift_z;
	view_board board;
	longint unsigned cycles;
	int stall_mode;

	look_at_view_matrix uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// timeout guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > TIMEOUT_CYCLES) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// result side: sample, check, stall on its own pattern
	initial begin
		view_t got;
		out_ready = 0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.ax = '{right_x, right_y, right_z, upward_x, upward_y, upward_z,
					back_x, back_y, back_z};
				got.sh = '{shift_x, shift_y, shift_z};
				board.check_view(got);
			end
			if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((cycles % 16) < 12);
			endcase
		end
	end

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
		endcase
	endfunction

	// drive one command and wait until it is taken
	task automatic send_command(logic [1:0] k, coord_t f[3], coord_t t[3], logic orb);
		in_valid <= 1'b1;
		kind <= k;
		{first_x, first_y, first_z} <= {f[0], f[1], f[2]};
		{target_x, target_y, target_z} <= {t[0], t[1], t[2]};
		orbit <= orb;
		do @(posedge clk); while (!in_ready);
		board.note_command(k, f, t, orb);
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_cycles(1);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	initial begin
		coord_t f[3], t[3];
		coord_t big, neg;
		int burst;
		board = new();
		arst_n = 0;
		in_valid = 0;
		kind = KIND_LOOK;
		{first_x, first_y, first_z, target_x, target_y, target_z} = '0;
		orbit = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, extremes, zero-length vectors, saturation
		big = 32'sh7fffffff;
		neg = 32'sh80000000;
		send_command(KIND_SPARE, '{1, 2, 3}, '{4, 5, 6}, 1);
		send_command(KIND_MOVE, '{0, 0, 0}, '{big, neg, big}, 1);
		send_command(KIND_LOOK, '{0, 0, 5 << 16}, '{0, 0, 0}, 1);
		send_command(KIND_LOOK, '{0, 0, 5 << 16}, '{0, 0, 0}, 0);
		send_command(KIND_LOOK, '{7, 7, 7}, '{7, 7, 7}, 1);
		send_command(KIND_LOOK, '{7, 7, 7}, '{7, 7, 7}, 0);
		send_command(KIND_LOOK, '{0, 100, 0}, '{0, 0, 0}, 1);
		send_command(KIND_LOOK, '{0, neg, 0}, '{0, big, 0}, 0);
		send_command(KIND_LOOK, '{big, big, big}, '{neg, neg, neg}, 1);
		send_command(KIND_LOOK, '{neg, big, neg}, '{big, neg, big}, 0);
		send_command(KIND_LOOK, '{big, big, big}, '{big, big, big - 1}, 0);
		send_command(KIND_MOVE, '{big, big, big}, '{0, 0, 0}, 0);
		send_command(KIND_MOVE, '{neg, neg, neg}, '{0, 0, 0}, 0);
		send_command(KIND_MOVE, '{neg, neg, neg}, '{0, 0, 0}, 1);
		send_command(KIND_AIM, '{big, 0, neg}, '{1, 1, 1}, 1);
		send_command(KIND_LOOK, '{1, 0, 0}, '{0, 0, 0}, 1);
		send_command(KIND_AIM, '{1, 0, 0}, '{0, 0, 0}, 0);
		send_command(KIND_AIM, '{1, 5, 0}, '{0, 0, 0}, 0);
		send_command(KIND_AIM, '{-3, 9, 2}, '{-1, -1, -1}, 1);
		send_command(KIND_SPARE, '{-1, -1, -1}, '{-1, -1, -1}, 0);

		// hold off until the directed part has fully drained
		drain();

		// random bursts
		for (int n = 0; n < 950; ) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && n < 950; b++, n++) begin
				for (int i = 0; i < 3; i++) begin
					f[i] = rand_coord();
					t[i] = ($urandom_range(0, 3) == 0) ? f[i] : rand_coord();
				end
				send_command(($urandom_range(0, 9) == 0) ? KIND_SPARE :
					2'($urandom_range(0, 2)), f, t, 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
		end

		in_valid <= 1'b0;
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
